// ===== sv/hbbc_pkg.sv =====
package hbbc_pkg;
	localparam int NUM_BUFFERS_DEF = 32;
	localparam int NUM_BUCKETS_DEF = 13;
	localparam logic [7:0] REFS_MAX = 8'hff;
	localparam logic [31:0] STAMP_BOUND = 32'h8fffffff;

	typedef enum logic [1:0] {
		FN_GET = 2'd0,
		FN_RELEASE = 2'd1,
		FN_PIN = 2'd2,
		FN_UNPIN = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_NO_FREE = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] device_id;
		logic [31:0] block_number;
		logic [4:0] buffer_index;
		logic [30:0] tick;
	} req_t;

	typedef struct packed {
		logic [4:0] entry_index;
		logic was_hit;
		logic read_needed;
		logic [1:0] status;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic mod_step;
		logic scan_clr;
		logic scan_step;
		logic scan2;
		logic commit;
		logic shift_step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic is_get;
		logic mod_done;
		logic scan_done;
		logic hit_or_free;
		logic shift_done;
	} sts_t;
endpackage

// ===== sv/hbbc_if.sv =====
interface hbbc_req_if import hbbc_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface hbbc_rsp_if import hbbc_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== sv/hbbc_ctrl.sv =====
module hbbc_ctrl import hbbc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	output cmd_t cmd,
	input sts_t sts
);
	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_MOD = 8'b0000_0010,
		S_SCAN1 = 8'b0000_0100,
		S_SCAN2 = 8'b0000_1000,
		S_COMMIT = 8'b0001_0000,
		S_SHIFT = 8'b0010_0000,
		S_FIN = 8'b0100_0000,
		S_OUT = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_MOD;
				end
			end
			S_MOD: begin
				cmd.mod_step = 1'b1;
				if (sts.mod_done) begin
					cmd.scan_clr = 1'b1;
					state_d = sts.is_get ? S_SCAN1 : S_FIN;
				end
			end
			S_SCAN1: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_done) begin
					if (sts.hit_or_free) begin
						state_d = S_COMMIT;
					end else begin
						cmd.scan_clr = 1'b1;
						state_d = S_SCAN2;
					end
				end
			end
			S_SCAN2: begin
				cmd.scan_step = 1'b1;
				cmd.scan2 = 1'b1;
				if (sts.scan_done) state_d = S_COMMIT;
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				cmd.scan_clr = 1'b1;
				state_d = S_SHIFT;
			end
			S_SHIFT: begin
				cmd.shift_step = 1'b1;
				if (sts.shift_done) state_d = S_FIN;
			end
			S_FIN: begin
				cmd.finish = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end
endmodule

// ===== sv/hbbc_dp.sv =====
module hbbc_dp import hbbc_pkg::*; #(
	parameter int NUM_BUFFERS = NUM_BUFFERS_DEF,
	parameter int NUM_BUCKETS = NUM_BUCKETS_DEF
) (
	input logic clk,
	input logic arst_n,
	input req_t req,
	output rsp_t rsp,
	input cmd_t cmd,
	output sts_t sts
);
	localparam int IW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
	localparam int CW = $clog2(NUM_BUFFERS + 1);
	localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int MW = 1;
	// block / NUM_BUCKETS as (block * RM) >> RS, exact for any 32-bit block
	localparam int RS = 32 + $clog2(NUM_BUCKETS);
	localparam logic [63:0] RM = ((64'd1 << RS) + 64'(NUM_BUCKETS) - 64'd1)
		/ 64'(NUM_BUCKETS);

	logic [7:0] dev_q [NUM_BUFFERS];
	logic [31:0] blk_q [NUM_BUFFERS];
	logic [7:0] refs_q [NUM_BUFFERS];
	logic [30:0] stamp_q [NUM_BUFFERS];
	logic [NUM_BUFFERS-1:0] valid_q;
	logic [BW-1:0] bucket_q [NUM_BUFFERS];
	logic [IW-1:0] rank_q [NUM_BUFFERS];

	req_t req_q;
	logic [31:0] quo_q;
	logic [MW-1:0] mcnt_q;
	logic [BW-1:0] home_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] home_cnt_q;
	logic hit_f_q, free_f_q, vic_f_q;
	logic [IW-1:0] hit_e_q, free_e_q, vic_e_q;
	logic [4:0] sel_q;
	logic [31:0] best_q;
	logic [BW-1:0] vbkt_q;
	logic [IW-1:0] vrank_q;
	logic steal_q, hitres_q, rn_q;
	logic [1:0] st_q;

	logic [IW-1:0] ce;
	logic in_range, cnt_end;
	logic [71:0] qprod;
	logic [31:0] rem_w;
	logic [IW-1:0] tgt;
	logic [31:0] st32;

	assign ce = cnt_q[IW-1:0];
	assign cnt_end = (cnt_q == CW'(NUM_BUFFERS - 1));
	assign in_range = (32'(req_q.buffer_index) < 32'(NUM_BUFFERS));
	assign tgt = IW'(req_q.buffer_index);
	assign st32 = {1'b0, stamp_q[ce]};

	assign qprod = 72'(req_q.block_number) * 72'(RM[32:0]);
	assign rem_w = req_q.block_number - quo_q * 32'(NUM_BUCKETS);

	assign sts.is_get = (req_q.func == FN_GET);
	assign sts.mod_done = (mcnt_q == MW'(1));
	assign sts.scan_done = cnt_end;
	assign sts.hit_or_free = hit_f_q || free_f_q
		|| (bucket_q[ce] == home_q && ((dev_q[ce] == req_q.device_id
		&& blk_q[ce] == req_q.block_number) || refs_q[ce] == 8'd0));
	assign sts.shift_done = cnt_end;

	assign rsp.entry_index = sel_q;
	assign rsp.was_hit = hitres_q;
	assign rsp.read_needed = rn_q;
	assign rsp.status = st_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
			mcnt_q <= '0;
		end
		if (cmd.mod_step) begin
			mcnt_q <= mcnt_q + MW'(1);
			if (sts.mod_done) home_q <= rem_w[BW-1:0];
			else quo_q <= qprod[RS +: 32];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			hit_f_q <= 1'b0;
			free_f_q <= 1'b0;
			vic_f_q <= 1'b0;
			steal_q <= 1'b0;
			home_cnt_q <= '0;
			best_q <= STAMP_BOUND;
			hitres_q <= 1'b0;
			rn_q <= 1'b0;
			st_q <= ST_OK;
			sel_q <= '0;
			hit_e_q <= '0;
			free_e_q <= '0;
			vic_e_q <= '0;
			vbkt_q <= '0;
			vrank_q <= '0;
			valid_q <= '0;
			for (int i = 0; i < NUM_BUFFERS; i++) begin
				dev_q[i] <= '0;
				blk_q[i] <= '0;
				refs_q[i] <= '0;
				stamp_q[i] <= '0;
				bucket_q[i] <= '0;
				rank_q[i] <= IW'(i);
			end
		end else begin
			if (cmd.load) begin
				hit_f_q <= 1'b0;
				free_f_q <= 1'b0;
				vic_f_q <= 1'b0;
				steal_q <= 1'b0;
				home_cnt_q <= '0;
				best_q <= STAMP_BOUND;
				hitres_q <= 1'b0;
				rn_q <= 1'b0;
				st_q <= ST_OK;
				sel_q <= req.buffer_index;
			end
			if (cmd.scan_step) begin
				cnt_q <= cnt_q + CW'(1);
				if (!cmd.scan2) begin
					if (bucket_q[ce] == home_q) begin
						home_cnt_q <= home_cnt_q + CW'(1);
						if (dev_q[ce] == req_q.device_id
							&& blk_q[ce] == req_q.block_number
							&& (!hit_f_q || rank_q[ce] < rank_q[hit_e_q])) begin
							hit_f_q <= 1'b1;
							hit_e_q <= ce;
						end
						if (refs_q[ce] == 8'd0
							&& (!free_f_q || rank_q[ce] > rank_q[free_e_q])) begin
							free_f_q <= 1'b1;
							free_e_q <= ce;
						end
					end
				end else if (bucket_q[ce] != home_q && refs_q[ce] == 8'd0) begin
					if (st32 < best_q || (vic_f_q && st32 == best_q
						&& (bucket_q[ce] < vbkt_q
						|| (bucket_q[ce] == vbkt_q && rank_q[ce] < vrank_q)))) begin
						best_q <= st32;
						vic_f_q <= 1'b1;
						vic_e_q <= ce;
						vbkt_q <= bucket_q[ce];
						vrank_q <= rank_q[ce];
					end
				end
			end
			if (cmd.scan_clr) cnt_q <= '0;
			if (cmd.commit) begin
				if (hit_f_q) begin
					sel_q <= 5'(hit_e_q);
					hitres_q <= 1'b1;
					rn_q <= !valid_q[hit_e_q];
					valid_q[hit_e_q] <= 1'b1;
					if (refs_q[hit_e_q] != REFS_MAX)
						refs_q[hit_e_q] <= refs_q[hit_e_q] + 8'd1;
					stamp_q[hit_e_q] <= req_q.tick;
				end else if (free_f_q || vic_f_q) begin
					sel_q <= 5'(free_f_q ? free_e_q : vic_e_q);
					rn_q <= 1'b1;
					steal_q <= !free_f_q;
					valid_q[free_f_q ? free_e_q : vic_e_q] <= 1'b1;
					dev_q[free_f_q ? free_e_q : vic_e_q] <= req_q.device_id;
					blk_q[free_f_q ? free_e_q : vic_e_q] <= req_q.block_number;
					refs_q[free_f_q ? free_e_q : vic_e_q] <= 8'd1;
					stamp_q[free_f_q ? free_e_q : vic_e_q] <= req_q.tick;
				end else begin
					sel_q <= '0;
					st_q <= ST_NO_FREE;
				end
			end
			if (cmd.shift_step) begin
				cnt_q <= cnt_q + CW'(1);
				if (steal_q) begin
					if (ce == vic_e_q) begin
						bucket_q[ce] <= home_q;
						rank_q[ce] <= home_cnt_q[IW-1:0];
					end else if (bucket_q[ce] == vbkt_q && rank_q[ce] > vrank_q) begin
						rank_q[ce] <= rank_q[ce] - IW'(1);
					end
				end
			end
			if (cmd.finish && !sts.is_get && in_range) begin
				if (req_q.func == FN_PIN) begin
					if (refs_q[tgt] != REFS_MAX) refs_q[tgt] <= refs_q[tgt] + 8'd1;
				end else if (refs_q[tgt] == 8'd0) begin
					st_q <= ST_UNDERFLOW;
				end else begin
					refs_q[tgt] <= refs_q[tgt] - 8'd1;
				end
			end
		end
	end
endmodule

// ===== sv/hashed_block_buffer_cache_policy_unit.sv =====
// channel | dir | payload
// req     | in  | func, device_id, block_number, buffer_index, tick
// rsp     | out | entry_index, was_hit, read_needed, status
// One request at a time. Release/pin/unpin: accept, bucket divide, update,
// response. Get: accept, divide, one scan or, when the home bucket has no hit
// and no free entry, two 32-entry scans, then a commit and a rank fix-up sweep,
// one entry a cycle each.
// Response is held in a register until taken; req ready is low until then.
// arst_n clears all entry state and control.
module hashed_block_buffer_cache_policy_unit import hbbc_pkg::*; #(
	parameter int NUM_BUFFERS = NUM_BUFFERS_DEF,
	parameter int NUM_BUCKETS = NUM_BUCKETS_DEF
) (
	input logic clk,
	input logic arst_n,
	hbbc_req_if.sink req,
	hbbc_rsp_if.source rsp
);
	cmd_t cmd;
	sts_t sts;

	hbbc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req.valid), .in_ready(req.ready),
		.out_valid(rsp.valid), .out_ready(rsp.ready),
		.cmd(cmd), .sts(sts)
	);

	hbbc_dp #(.NUM_BUFFERS(NUM_BUFFERS), .NUM_BUCKETS(NUM_BUCKETS)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.req(req.data), .rsp(rsp.data),
		.cmd(cmd), .sts(sts)
	);

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.ready && rsp.valid)) else $error("ready during response");
	a_nofree: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.data.status == ST_NO_FREE) |-> !rsp.data.was_hit)
		else $error("no-free with hit");
	a_hitrn: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.data.status != ST_OK) |-> !rsp.data.read_needed)
		else $error("error with read");
endmodule

// ===== verif/hbbc_tb_if.sv =====
`timescale 1ns / 1ps

// ===== verif/hbbc_checker.sv =====
`timescale 1ns / 1ps

module hbbc_checker import hbbc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input req_t req_data,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp_data,
	output int errors,
	output int pending
);
	localparam int NB = NUM_BUFFERS_DEF;
	localparam int NK = NUM_BUCKETS_DEF;

	logic [7:0] tag_dev [NB];
	logic [31:0] tag_blk [NB];
	logic [7:0] refs [NB];
	logic [31:0] stamp [NB];
	logic valid_q [NB];
	logic [7:0] bucket [NB];
	int rank [NB];
	rsp_t expected_rsps [$];

	initial begin
		errors = 0;
		pending = 0;
		for (int e = 0; e < NB; e++) begin
			tag_dev[e] = '0;
			tag_blk[e] = '0;
			refs[e] = '0;
			stamp[e] = '0;
			valid_q[e] = 1'b0;
			bucket[e] = '0;
			rank[e] = e;
		end
	end

	function automatic rsp_t predict_cache(req_t r);
		rsp_t o;
		int home, hit, freeh, victim, hc, e;
		logic [31:0] best;
		o = '0;
		if (r.func != FN_GET) begin
			o.entry_index = r.buffer_index;
			o.status = ST_OK;
			if (int'(r.buffer_index) >= NB)
				return o;
			if (r.func == FN_PIN) begin
				if (refs[r.buffer_index] != REFS_MAX)
					refs[r.buffer_index]++;
			end else if (refs[r.buffer_index] == 0) begin
				o.status = ST_UNDERFLOW;
			end else begin
				refs[r.buffer_index]--;
			end
			return o;
		end
		home = r.block_number % NK;
		hit = -1;
		freeh = -1;
		victim = -1;
		hc = 0;
		best = STAMP_BOUND;
		for (int k = 0; k < NB; k++) begin
			if (bucket[k] != home)
				continue;
			hc++;
			if (tag_dev[k] == r.device_id && tag_blk[k] == r.block_number &&
					(hit < 0 || rank[k] < rank[hit]))
				hit = k;
			if (refs[k] == 0 && (freeh < 0 || rank[k] > rank[freeh]))
				freeh = k;
		end
		if (hit >= 0) begin
			e = hit;
			if (refs[e] != REFS_MAX)
				refs[e]++;
			stamp[e] = {1'b0, r.tick};
			o.was_hit = 1'b1;
		end else begin
			if (freeh >= 0) begin
				e = freeh;
			end else begin
				for (int k = 0; k < NB; k++) begin
					if (bucket[k] == home || refs[k] != 0)
						continue;
					if (stamp[k] < best || (victim >= 0 && stamp[k] == best &&
							(bucket[k] < bucket[victim] || (bucket[k] == bucket[victim]
							&& rank[k] < rank[victim])))) begin
						best = stamp[k];
						victim = k;
					end
				end
				if (victim < 0) begin
					o.status = ST_NO_FREE;
					return o;
				end
				for (int k = 0; k < NB; k++)
					if (bucket[k] == bucket[victim] && rank[k] > rank[victim])
						rank[k]--;
				bucket[victim] = home;
				rank[victim] = hc;
				e = victim;
			end
			tag_dev[e] = r.device_id;
			tag_blk[e] = r.block_number;
			valid_q[e] = 1'b0;
			refs[e] = 8'd1;
			stamp[e] = {1'b0, r.tick};
		end
		o.entry_index = e;
		o.read_needed = !valid_q[e];
		valid_q[e] = 1'b1;
		return o;
	endfunction

	always @(posedge clk) begin
		rsp_t exp_r;
		if (arst_n) begin
			if (req_valid && req_ready)
				expected_rsps.push_back(predict_cache(req_data));
			if (rsp_valid && rsp_ready) begin
				if (expected_rsps.size() == 0) begin
					$display("%0t: unexpected response %p", $time, rsp_data);
					errors++;
				end else begin
					exp_r = expected_rsps.pop_front();
					if (rsp_data !== exp_r) begin
						$display("%0t: mismatch expected %p actual %p", $time, exp_r,
							rsp_data);
						errors++;
					end
				end
			end
			pending = expected_rsps.size();
		end
	end
endmodule

// ===== verif/tb_hashed_block_buffer_cache_policy_unit.sv =====
`timescale 1ns / 1ps

module tb_hashed_block_buffer_cache_policy_unit;
	import hbbc_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int errors, pending;
	int send_idle = 0, recv_stall = 0;
	bit hold_off = 0;
	int unsigned cycles = 0;
	localparam int unsigned CYCLE_LIMIT = 2000000;

	hbbc_req_if req_ch();
	hbbc_rsp_if rsp_ch();

	hashed_block_buffer_cache_policy_unit u_dut (
		.clk(clk), .arst_n(arst_n), .req(req_ch.sink), .rsp(rsp_ch.source));

	hbbc_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_ch.valid), .req_ready(req_ch.ready), .req_data(req_ch.data),
		.rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready), .rsp_data(rsp_ch.data),
		.errors(errors), .pending(pending));

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		rsp_ch.ready = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[hashed_block_buffer_cache_policy_unit] ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_off)
			rsp_ch.ready <= 1'b0;
		else
			rsp_ch.ready <= ($urandom_range(99) >= recv_stall);
	end

	// small block pool so gets hit, collide and run out of buffers
	function automatic req_t rand_request();
		req_t r;
		r.func = $urandom_range(3);
		if ($urandom_range(9) < 5)
			r.func = FN_GET;
		r.device_id = ($urandom_range(9) < 7) ? $urandom_range(2) : $urandom;
		r.block_number = ($urandom_range(9) < 7) ? $urandom_range(40) : $urandom;
		if ($urandom_range(19) == 0)
			r.block_number = 32'hffff_ffff;
		r.buffer_index = $urandom;
		r.tick = ($urandom_range(9) < 6) ? $urandom_range(20) : $urandom;
		return r;
	endfunction

	// valid stays high after an accept; a later call drops it while idling, or the caller drops it
	task automatic send_request(input req_t r);
		while ($urandom_range(99) < send_idle) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= r;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	task automatic directed_requests();
		req_t r;
		r = '0;
		send_request(r);
		r.tick = 31'h7fff_ffff;
		r.block_number = 32'hffff_ffff;
		r.device_id = 8'hff;
		send_request(r);
		send_request(r);
		for (int i = 0; i < 4; i++) begin
			r = '0;
			r.func = func_t'(i);
			r.buffer_index = 5'd31;
			send_request(r);
			r.buffer_index = 5'd0;
			send_request(r);
		end
		r = '0;
		r.func = FN_RELEASE;
		r.buffer_index = 5'd17;
		send_request(r);
		r.func = FN_UNPIN;
		send_request(r);
		r.func = FN_PIN;
		for (int i = 0; i < 8; i++)
			send_request(r);
	endtask

	initial begin
		int recv_modes [4] = '{0, 0, 84, 7};
		int send_modes [4] = '{0, 84, 0, 7};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_requests();
		// pin one entry up to saturation
		begin
			req_t r;
			r = '0;
			r.func = FN_PIN;
			r.buffer_index = 5'd5;
			repeat (260)
				send_request(r);
		end
		for (int ph = 0; ph < 4; ph++) begin
			send_idle = send_modes[ph];
			recv_stall = recv_modes[ph];
			repeat (130)
				send_request(rand_request());
		end
		send_idle = 0;
		recv_stall = 0;
		fork
			begin
				hold_off = 1;
				repeat (600) @(posedge clk);
				hold_off = 0;
			end
			begin
				repeat (50) send_request(rand_request());
				req_ch.valid <= 1'b0;
			end
		join
		while (pending != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("[hashed_block_buffer_cache_policy_unit] OK");
		else
			$display("[hashed_block_buffer_cache_policy_unit] ERROR");
		$finish;
	end
endmodule

// ===== hashed_block_buffer_cache_policy_unit.f =====
sv/hbbc_pkg.sv
sv/hbbc_if.sv
sv/hbbc_ctrl.sv
sv/hbbc_dp.sv
sv/hashed_block_buffer_cache_policy_unit.sv
verif/hbbc_tb_if.sv
verif/hbbc_checker.sv
verif/tb_hashed_block_buffer_cache_policy_unit.sv
